/* src/bfa_pkg.sv */
// Shared constants, payload types and memory request types of the frame allocator.
package bfa_pkg;

	localparam int BITMAP_WORDS = 32768;
	localparam int WORD_BITS    = 32;
	localparam int PAGE_SHIFT   = 12;
	localparam int FRAME_W      = 32 - PAGE_SHIFT;
	localparam int FC_W         = 21;

	// Summary levels: one bit per lower-level word, set when that word is full
	localparam int L1_WORDS = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int L2_WORDS = (L1_WORDS + WORD_BITS - 1) / WORD_BITS;

	localparam int L0_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int L1_AW = (L1_WORDS > 1) ? $clog2(L1_WORDS) : 1;
	localparam int L2_AW = (L2_WORDS > 1) ? $clog2(L2_WORDS) : 1;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] phys_address;
	} bfa_in_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic [1:0]  status;
	} bfa_out_t;

	typedef struct packed {
		logic             we;
		logic [L0_AW-1:0] addr;
		logic [31:0]      wdata;
	} l0_req_t;

	typedef struct packed {
		logic             we;
		logic [L1_AW-1:0] addr;
		logic [31:0]      wdata;
	} l1_req_t;

	typedef struct packed {
		logic             we;
		logic [L2_AW-1:0] addr;
		logic [31:0]      wdata;
	} l2_req_t;

endpackage

/* src/bfa_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* src/bfa_ctrl.sv */
// Command sequencer: clearing pass, hierarchical free-word search and read-modify-write.
module bfa_ctrl import bfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bfa_in_t          in_data,
	input  logic [FC_W-1:0]  frame_count,
	output logic             res_valid,
	input  logic             res_ready,
	output bfa_out_t         res_data,
	output l0_req_t          l0_req,
	output l1_req_t          l1_req,
	output l2_req_t          l2_req,
	input  logic [31:0]      l0_rdata,
	input  logic [31:0]      l1_rdata,
	input  logic [31:0]      l2_rdata
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_A_L2   = 3'd2;
	localparam logic [2:0] S_A_L1   = 3'd3;
	localparam logic [2:0] S_UPDATE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
	} zsearch_t;

	function automatic zsearch_t lowest_zero(input logic [31:0] w);
		zsearch_t r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!w[i]) begin
				r.found = 1'b1;
				r.idx   = 5'(i);
			end
		end
		return r;
	endfunction

	logic [2:0]          state_q, state_d;
	logic [L0_AW-1:0]    clr_q;
	logic [L2_WORDS-1:0] l3_full_q;
	logic [1:0]          cmd_q;
	logic [FRAME_W-1:0]  f_q, f_d;
	bfa_out_t            res_q, res_d;

	logic                accept;
	logic                in_range;
	logic [FRAME_W-1:0]  frame_in;
	zsearch_t            z3, z2, z1, z0;
	logic [FRAME_W-6:0]  word_cand;
	logic [15:0]         lim_words;
	logic                cand_ok;
	logic [4:0]          b0;
	logic [31:0]         bit0, new0, new1, new2;
	logic                full0, full1, full2;
	logic                upd_ok, upd;
	logic                clearing;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign clearing = (state_q == S_CLEAR);

	assign frame_in = in_data.phys_address[31:PAGE_SHIFT];
	assign in_range = 32'(frame_in[FRAME_W-1:5]) < BITMAP_WORDS;

	// lowest summary word that still has a non-full entry
	always_comb begin
		z3 = '0;
		for (int i = L2_WORDS - 1; i >= 0; i--) begin
			if (!l3_full_q[i]) begin
				z3.found = 1'b1;
				z3.idx   = 5'(i);
			end
		end
	end

	assign z2 = lowest_zero(l2_rdata);
	assign z1 = lowest_zero(l1_rdata);
	assign z0 = lowest_zero(l0_rdata);

	assign word_cand = {f_q[FRAME_W-1:10], z1.idx};
	assign lim_words = frame_count[FC_W-1:5];
	assign cand_ok   = z1.found && (32'(word_cand) < 32'(lim_words))
		&& (32'(word_cand) < BITMAP_WORDS);

	// modify all three levels in one pass so the summaries track the bitmap
	always_comb begin
		b0    = (cmd_q == CMD_ALLOC) ? z0.idx : f_q[4:0];
		bit0  = 32'd1 << b0;
		new0  = (cmd_q == CMD_FREE) ? (l0_rdata & ~bit0) : (l0_rdata | bit0);
		full0 = &new0;
		new1  = l1_rdata;
		new1[f_q[9:5]] = full0;
		full1 = &new1;
		new2  = l2_rdata;
		new2[f_q[14:10]] = full1;
		full2 = &new2;
	end

	assign upd_ok = (cmd_q != CMD_ALLOC) || z0.found;
	assign upd    = (state_q == S_UPDATE) && upd_ok;

	always_comb begin
		state_d = state_q;
		f_d     = f_q;
		res_d   = res_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == L0_AW'(BITMAP_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					res_d = '0;
					case (in_data.command)
						CMD_ALLOC: begin
							if (z3.found) begin
								f_d     = {z3.idx, 15'd0};
								state_d = S_A_L2;
							end else begin
								res_d.status = ST_NOMEM;
								state_d      = S_DONE;
							end
						end
						CMD_FREE, CMD_MARK: begin
							if (in_range) begin
								f_d     = frame_in;
								state_d = S_UPDATE;
							end else begin
								res_d.status = ST_RANGE;
								state_d      = S_DONE;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_A_L2: begin
				if (z2.found) begin
					f_d     = {f_q[FRAME_W-1:15], z2.idx, 10'd0};
					state_d = S_A_L1;
				end else begin
					res_d.status = ST_NOMEM;
					state_d      = S_DONE;
				end
			end
			S_A_L1: begin
				if (cand_ok) begin
					f_d     = {word_cand, 5'd0};
					state_d = S_UPDATE;
				end else begin
					res_d.status = ST_NOMEM;
					state_d      = S_DONE;
				end
			end
			S_UPDATE: begin
				if (!upd_ok) begin
					res_d.status = ST_NOMEM;
				end else if (cmd_q == CMD_ALLOC) begin
					res_d.frame_address = {f_q[FRAME_W-1:5], z0.idx, 12'd0};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// reads follow the next frame; in the update cycle that equals the held frame
	always_comb begin
		l0_req.we    = clearing || upd;
		l0_req.addr  = clearing ? clr_q : L0_AW'(f_d[FRAME_W-1:5]);
		l0_req.wdata = clearing ? 32'd0 : new0;

		l1_req.we    = (clearing && (32'(clr_q) < L1_WORDS)) || upd;
		l1_req.addr  = clearing ? L1_AW'(clr_q) : L1_AW'(f_d[FRAME_W-1:10]);
		l1_req.wdata = clearing ? 32'd0 : new1;

		l2_req.we    = (clearing && (32'(clr_q) < L2_WORDS)) || upd;
		l2_req.addr  = clearing ? L2_AW'(clr_q) : L2_AW'(f_d[FRAME_W-1:15]);
		l2_req.wdata = clearing ? 32'd0 : new2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			l3_full_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (upd) begin
				l3_full_q[L2_AW'(f_q[FRAME_W-1:15])] <= full2;
			end
		end
	end

	always_ff @(posedge clk) begin
		f_q   <= f_d;
		res_q <= res_d;
		if (accept) begin
			cmd_q <= in_data.command;
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res_data  = res_q;

endmodule

/* src/bitmap_frame_allocator_top.sv */
// Allocate steps S_A_L2, S_A_L1, S_UPDATE, then S_DONE holds the result; a failed allocate
// ends from S_A_L1 at the search bound, or from idle on a full bitmap. Free and mark-used
// step S_UPDATE only; range errors and unknown commands go straight to S_DONE. No new item
// is taken until the result is handed on. Each step reads one bitmap level RAM (registered
// read data). After reset a clearing pass zeroes BITMAP_WORDS (32768) words, in_stall high;
// frame_count resets to 0; the user must write it only with no item in flight (not enforced).
module bitmap_frame_allocator_top import bfa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bfa_in_t         in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bfa_out_t        out_data,
	input  logic            cfg_we,
	input  logic [FC_W-1:0] cfg_wdata
);

	logic [FC_W-1:0] frame_count_q;
	logic            out_valid_q;
	bfa_out_t        out_data_q;

	logic            res_valid, res_ready;
	bfa_out_t        res_data;
	l0_req_t         l0_req;
	l1_req_t         l1_req;
	l2_req_t         l2_req;
	logic [31:0]     l0_rdata, l1_rdata, l2_rdata;

	bfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.frame_count (frame_count_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data),
		.l0_req      (l0_req),
		.l1_req      (l1_req),
		.l2_req      (l2_req),
		.l0_rdata    (l0_rdata),
		.l1_rdata    (l1_rdata),
		.l2_rdata    (l2_rdata)
	);

	bfa_ram #(.WIDTH(32), .DEPTH(BITMAP_WORDS)) u_l0_ram (
		.clk   (clk),
		.we    (l0_req.we),
		.addr  (l0_req.addr),
		.wdata (l0_req.wdata),
		.rdata (l0_rdata)
	);

	bfa_ram #(.WIDTH(32), .DEPTH(L1_WORDS)) u_l1_ram (
		.clk   (clk),
		.we    (l1_req.we),
		.addr  (l1_req.addr),
		.wdata (l1_req.wdata),
		.rdata (l1_rdata)
	);

	bfa_ram #(.WIDTH(32), .DEPTH(L2_WORDS)) u_l2_ram (
		.clk   (clk),
		.we    (l2_req.we),
		.addr  (l2_req.addr),
		.wdata (l2_req.wdata),
		.rdata (l2_rdata)
	);

	// hand a finished item over whenever the output register is empty or draining
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
